### hdl/md5_pkg.sv
// md5 hasher shared types, constants and round tables
`timescale 1ns / 1ps
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // 64 bytes, byte j at bits 8j, so word w holds bytes 4w..4w+3 little-endian
  typedef logic [63:0][7:0]  blk_bytes_t;
  typedef logic [15:0][31:0] blk_words_t;

  typedef struct packed {
    blk_bytes_t blk;
    logic       is_final;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_FLUSH, F_PAD, F_LEN} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_RUN, B_ADD, B_EMIT} back_state_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  localparam logic [63:0][31:0] ADD_CONST = {
    32'heb86d391, 32'h2ad7d2bb, 32'hbd3af235, 32'hf7537e82,
    32'h4e0811a1, 32'ha3014314, 32'hfe2ce6e0, 32'h6fa87e4f,
    32'h85845dd1, 32'hffeff47d, 32'h8f0ccc92, 32'h655b59c3,
    32'hfc93a039, 32'hab9423a7, 32'h432aff97, 32'hf4292244,
    32'hc4ac5665, 32'h1fa27cf8, 32'he6db99e5, 32'hd9d4d039,
    32'h04881d05, 32'hd4ef3085, 32'heaa127fa, 32'h289b7ec6,
    32'hbebfbc70, 32'hf6bb4b60, 32'h4bdecfa9, 32'ha4beea44,
    32'hfde5380c, 32'h6d9d6122, 32'h8771f681, 32'hfffa3942,
    32'h8d2a4c8a, 32'h676f02d9, 32'hfcefa3f8, 32'ha9e3e905,
    32'h455a14ed, 32'hf4d50d87, 32'hc33707d6, 32'h21e1cde6,
    32'he7d3fbc8, 32'hd8a1e681, 32'h02441453, 32'hd62f105d,
    32'he9b6c7aa, 32'h265e5a51, 32'hc040b340, 32'hf61e2562,
    32'h49b40821, 32'ha679438e, 32'hfd987193, 32'h6b901122,
    32'h895cd7be, 32'hffff5bb1, 32'h8b44f7af, 32'h698098d8,
    32'hfd469501, 32'ha8304613, 32'h4787c62a, 32'hf57c0faf,
    32'hc1bdceee, 32'h242070db, 32'he8c7b756, 32'hd76aa478
  };

  localparam logic [15:0][4:0] ROT_AMT = {
    5'd21, 5'd15, 5'd10, 5'd6, 5'd23, 5'd16, 5'd11, 5'd4,
    5'd20, 5'd14, 5'd9,  5'd5, 5'd22, 5'd17, 5'd12, 5'd7
  };

endpackage

### hdl/md5_job_q.sv
// two-entry block queue between byte packer and round engine
`timescale 1ns / 1ps
module md5_job_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  md5_pkg::job_t  push_data,
  input  logic           pop,
  output md5_pkg::job_t  head,
  output md5_pkg::q_stat_t stat
);
  import md5_pkg::*;

  job_t       mem [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign head = mem[rd_r];

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

### hdl/md5_front.sv
// byte packer: builds 64-byte blocks, counts bits and emits padded blocks
`timescale 1ns / 1ps
module md5_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  md5_pkg::in_item_t in_item,
  input  md5_pkg::q_stat_t q_stat,
  output logic             q_push,
  output md5_pkg::job_t    q_data
);
  import md5_pkg::*;

  front_state_t state_r, state_nxt;
  blk_bytes_t   buf_r;
  logic [63:0]  cnt_r, cnt_nxt;
  logic         last_pend_r, last_pend_nxt;
  logic [5:0]   pos;
  logic         accept;
  blk_bytes_t   padded;

  assign pos    = cnt_r[8:3];
  assign in_full = (state_r != F_IDLE);
  assign accept = in_push && !in_full;

  // message bytes below pos, then the pad marker, then zeros
  always_comb begin
    for (int j = 0; j < 64; j++) begin
      if (6'(j) < pos) begin
        padded[j] = buf_r[j];
      end else if (6'(j) == pos) begin
        padded[j] = PAD_BYTE;
      end else begin
        padded[j] = 8'h00;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_pend_nxt = last_pend_r;
    q_push        = 1'b0;
    q_data.blk    = buf_r;
    q_data.is_final = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          last_pend_nxt = in_item.last_byte;
          if (in_item.data_valid) begin
            cnt_nxt = cnt_r + 64'd8;
            if (pos == 6'd63) begin
              state_nxt = F_FLUSH;
            end else if (in_item.last_byte) begin
              state_nxt = F_PAD;
            end
          end else if (in_item.last_byte) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_FLUSH: begin
        q_push = 1'b1;
        if (!q_stat.full) begin
          state_nxt = last_pend_r ? F_PAD : F_IDLE;
        end
      end
      F_PAD: begin
        q_push     = 1'b1;
        q_data.blk = padded;
        if (pos < LEN_POS) begin
          q_data.blk[63:56] = cnt_r;
          q_data.is_final   = 1'b1;
          if (!q_stat.full) begin
            state_nxt = F_IDLE;
            cnt_nxt   = 64'd0;
          end
        end else if (!q_stat.full) begin
          state_nxt = F_LEN;
        end
      end
      F_LEN: begin
        q_push            = 1'b1;
        q_data.blk        = '0;
        q_data.blk[63:56] = cnt_r;
        q_data.is_final   = 1'b1;
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
          cnt_nxt   = 64'd0;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      cnt_r       <= 64'd0;
      last_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.data_valid) begin
      buf_r[pos] <= in_item.data_byte;
    end
  end

endmodule

### hdl/md5_round.sv
// round engine: one md5 round per cycle, chaining words and digest queue
`timescale 1ns / 1ps
module md5_round (
  input  logic               clk,
  input  logic               rst_n,
  input  md5_pkg::job_t      job,
  input  md5_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output md5_pkg::out_item_t out_item
);
  import md5_pkg::*;

  back_state_t  state_r, state_nxt;
  blk_words_t   blk_r, blk_nxt;
  logic         fin_r, fin_nxt;
  logic [3:0][31:0] chain_r, chain_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]   step_r, step_nxt;
  logic [1:0]   idx_r, idx_nxt;

  out_item_t    omem [4];
  logic [1:0]   owr_r, ord_r;
  logic [2:0]   ocnt_r;
  logic         opush, opop;
  out_item_t    opush_data;

  logic [1:0]   phase;
  logic [3:0]   s4, g;
  logic [31:0]  f, t;
  logic [63:0]  rot_dbl;

  assign phase = step_r[5:4];
  assign s4    = step_r[3:0];

  always_comb begin
    case (phase)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = s4;
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        g = 4'(s4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'(s4 * 4'd3 + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'(s4 * 4'd7);
      end
    endcase
    t = a_r + f + blk_r[g] + ADD_CONST[step_r];
    rot_dbl = {t, t} << ROT_AMT[{phase, step_r[1:0]}];
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    fin_nxt   = fin_r;
    chain_nxt = chain_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    opush     = 1'b0;
    opush_data.digest_word = chain_r[idx_r];
    opush_data.word_index  = idx_r;
    opush_data.last_word   = (idx_r == 2'd3);
    case (state_r)
      B_IDLE: begin
        // a final block waits until the digest queue has drained
        if (!q_stat.empty && (!job.is_final || ocnt_r == 3'd0)) begin
          q_pop     = 1'b1;
          blk_nxt   = job.blk;
          fin_nxt   = job.is_final;
          a_nxt = chain_r[0]; b_nxt = chain_r[1];
          c_nxt = chain_r[2]; d_nxt = chain_r[3];
          step_nxt  = 6'd0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        a_nxt = d_r;
        d_nxt = c_r;
        c_nxt = b_r;
        b_nxt = b_r + rot_dbl[63:32];
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        idx_nxt   = 2'd0;
        state_nxt = fin_r ? B_EMIT : B_IDLE;
      end
      B_EMIT: begin
        opush   = 1'b1;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          chain_nxt = {INIT_D, INIT_C, INIT_B, INIT_A};
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      chain_r <= {INIT_D, INIT_C, INIT_B, INIT_A};
      idx_r   <= 2'd0;
      step_r  <= 6'd0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      idx_r   <= idx_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    fin_r <= fin_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
  end

  // digest queue
  assign out_empty = (ocnt_r == 3'd0);
  assign opop      = out_pop && !out_empty;
  assign out_item  = omem[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 2'd0;
      ord_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      if (opush) begin
        owr_r <= owr_r + 2'd1;
      end
      if (opop) begin
        ord_r <= ord_r + 2'd1;
      end
      ocnt_r <= ocnt_r + {2'b0, opush} - {2'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      omem[owr_r] <= opush_data;
    end
  end

`ifndef SYNTHESIS
  a_ocnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 3'd4) else $error("digest queue overflow");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> ocnt_r != 3'd4) else $error("emit into full queue");
  a_fin_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD && fin_r) |=> state_r == B_EMIT)
    else $error("final block did not emit");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && q_pop) |=> (state_r == B_RUN && step_r == 6'd0))
    else $error("round count not restarted");
`endif

endmodule

### hdl/md5_stream_hasher.sv
// md5 stream hasher top level: byte packer, block queue, round engine
`timescale 1ns / 1ps
//  channel | direction | handshake          | payload
//  in_     | input     | in_push / in_full  | in_item: data_byte, data_valid, last_byte
//  out_    | output    | out_pop / out_empty| out_item: digest_word, word_index, last_word
//
//  one item per cycle into the packer while in_full is low; after the 64th byte
//  of a block in_full stays high while the block goes to the two-entry queue
//  the round engine loads a block, runs the 64 rounds and adds the chaining words;
//  a long message runs at about one byte per cycle; the last item costs 1 to 2
//  extra blocks plus four words of digest output
//  in_full is high while the packer hands a full block to the block queue or pads
//  synchronous active-low reset restores the md5 initial chaining words
module md5_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  md5_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output md5_pkg::out_item_t out_item
);
  import md5_pkg::*;

  // front side to block queue
  logic    q_push, q_pop;
  job_t    q_data, q_head;
  q_stat_t q_stat;

  md5_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  // short queue so packing and rounds stall independently
  md5_job_q u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // round engine with the digest queue at its output
  md5_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### verif/md5_stream_hasher_tb.sv
// testbench for the md5 stream hasher: directed table, random messages, digest checks
`timescale 1ns / 1ps
module md5_stream_hasher_tb;
  import md5_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  md5_stream_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: chaining words, byte buffer, running length in bits
  logic [31:0] hash_chain [4];
  logic [7:0]  msg_buf [64];
  logic [63:0] msg_bits;
  out_item_t   digest_q [$];
  int          err_count = 0;
  bit          stim_done = 1'b0;

  localparam logic [31:0] SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                          6, 10, 15, 21};

  function automatic logic [31:0] sine_const(int i);
    sine_const = ADD_CONST[i];
  endfunction

  task automatic hash_restart();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hefcdab89;
    hash_chain[2] = 32'h98badcfe;
    hash_chain[3] = 32'h10325476;
    msg_bits = '0;
  endtask

  task automatic run_rounds();
    logic [31:0] a, b, c, d, f, t, w;
    int g;
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    for (int s = 0; s < 64; s++) begin
      case (s / 16)
        0: begin f = (b & c) | (~b & d); g = s; end
        1: begin f = (b & d) | (c & ~d); g = (5 * s + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * s + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * s) % 16; end
      endcase
      w = {msg_buf[4*g+3], msg_buf[4*g+2], msg_buf[4*g+1], msg_buf[4*g]};
      t = a + f + w + sine_const(s);
      a = d; d = c; c = b;
      b = b + ((t << SHIFTS[(s / 16) * 4 + s % 4]) |
               (t >> (32 - SHIFTS[(s / 16) * 4 + s % 4])));
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
  endtask

  // fold one accepted item into the predictor, queue the digest on a closing item
  task automatic predict_item(in_item_t it);
    int pos;
    if (it.data_valid) begin
      pos = msg_bits[8:3];
      msg_buf[pos] = it.data_byte;
      msg_bits += 64'd8;
      if (pos == 63) run_rounds();
    end
    if (it.last_byte) begin
      pos = msg_bits[8:3];
      msg_buf[pos] = PAD_BYTE;
      for (int k = pos + 1; k < 64; k++) msg_buf[k] = 8'h00;
      if (pos >= 56) begin
        run_rounds();
        for (int k = 0; k < 64; k++) msg_buf[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) msg_buf[56 + k] = msg_bits[8*k +: 8];
      run_rounds();
      for (int k = 0; k < 4; k++)
        digest_q.push_back('{digest_word: hash_chain[k], word_index: 2'(k),
                             last_word: (k == 3)});
      hash_restart();
    end
  endtask

  // no gap half the time, otherwise mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) gap_len = 0;
    else if (r < 92) gap_len = $urandom_range(1, 3);
    else gap_len = $urandom_range(10, 60);
  endfunction

  // push one item, hold until accepted at a rising edge
  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    predict_item(it);
    @(negedge clk);
  endtask

  // directed table: empty message, one byte, extremes, block boundary lengths
  typedef struct {
    int        len;
    bit        tail_empty;
    logic [7:0] fill;
  } msg_row_t;

  localparam int N_ROWS = 8;
  msg_row_t dir_tab [N_ROWS] = '{
    '{0, 1'b1, 8'h00},   // empty message via a bare closing item
    '{1, 1'b0, 8'h00},
    '{1, 1'b0, 8'hff},
    '{3, 1'b1, 8'h61},
    '{55, 1'b0, 8'haa},  // padding just fits
    '{56, 1'b0, 8'h55},  // padding spills into an extra block
    '{63, 1'b1, 8'hff},
    '{64, 1'b0, 8'h01}   // exact block, padding goes in a fresh block
  };

  // md5 of the empty string, read straight off the standard
  localparam logic [31:0] EMPTY_MD5 [4] = '{32'hd98c1dd4, 32'h04b2008f, 32'h980980e9,
                                            32'h7e42f8ec};

  task automatic send_msg(int len, bit tail_empty, int mode, logic [7:0] fill);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      // sprinkle idle items with junk bytes that must be ignored
      if (mode != 0 && $urandom_range(0, 9) == 0)
        send_item('{data_byte: 8'($urandom), data_valid: 1'b0, last_byte: 1'b0});
      it.data_byte = (mode == 0) ? fill : 8'($urandom);
      it.data_valid = 1'b1;
      it.last_byte = (i == len - 1) && !tail_empty;
      send_item(it);
    end
    if (tail_empty || len == 0)
      send_item('{data_byte: 8'($urandom), data_valid: 1'b0, last_byte: 1'b1});
  endtask

  // stimulus
  initial begin
    int sent;
    int len;
    hash_restart();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_ROWS; r++)
      send_msg(dir_tab[r].len, dir_tab[r].tail_empty, 0, dir_tab[r].fill);
    // random messages, mostly short so many digests come out
    sent = 0;
    while (sent < 120) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_msg(len, $urandom_range(0, 1), 1, 8'h00);
      sent += len + 1;
    end
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // the empty-message digest is checked against the fixed value as well
  int empty_words = 4;

  // result side: random pop gaps, compare each popped item with the oldest digest
  initial begin
    out_item_t exp_item;
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (!out_empty) begin
        if (digest_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected digest item %h", out_item);
        end else begin
          exp_item = digest_q.pop_front();
          if (empty_words > 0) begin
            // first message is the empty one
            if (exp_item.digest_word !== EMPTY_MD5[4 - empty_words]) begin
              err_count++;
              if (err_count <= 10)
                $display("empty digest mismatch: exp %h, predicted %h",
                         EMPTY_MD5[4 - empty_words], exp_item.digest_word);
            end
            empty_words--;
          end
          if (out_item !== exp_item) begin
            err_count++;
            if (err_count <= 10)
              $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                       exp_item.digest_word, exp_item.word_index, exp_item.last_word,
                       out_item.digest_word, out_item.word_index, out_item.last_word);
          end
        end
      end
    end
  end

  // end of run: drain, settle, report
  initial begin
    wait (stim_done);
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (err_count == 0 && digest_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
